// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked property checks with disable iff reset gating
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_PROP(label, clk, rst, !(expr), msg)

`endif

// ===== sv/adsb_pkg.sv =====
// ----------------------------------------------------------------------------
// adsb_pkg
// shared types, constants and tables of the extended squitter encoder
// ----------------------------------------------------------------------------
package adsb_pkg;

   localparam logic [7:0]  FRAME_HEAD   = 8'h8D;
   localparam logic [3:0]  LAST_BYTE    = 4'd13;

   localparam logic [1:0]  KIND_ID      = 2'd0;
   localparam logic [1:0]  KIND_ODD     = 2'd1;
   localparam logic [1:0]  KIND_EVEN    = 2'd2;

   localparam logic [2:0]  CNT_LAST     = 3'd6;

   localparam logic [4:0]  TC_IDENT     = 5'd4;
   localparam logic [2:0]  CAT_IDENT    = 3'd7;
   localparam logic [4:0]  TC_AIRPOS    = 5'd9;

   localparam logic [5:0]  NL_COUNT     = 6'd58;
   localparam logic [6:0]  NL_MAX       = 7'd59;
   localparam logic [5:0]  ZONES_LAT    = 6'd60;
   localparam logic [24:0] NL_SCALE     = 25'd17578125;

   localparam logic signed [16:0] ALT_MIN = -17'sd1000;
   localparam logic signed [16:0] ALT_MAX = 17'sd50175;
   localparam logic [16:0] ALT_OFFSET   = 17'd1000;
   localparam logic [16:0] RECIP_25     = 17'd83887;

   localparam logic [31:0] CPR_HALF     = 32'd16384;

   localparam logic [1:0]  CSR_ICAO     = 2'd0;
   localparam logic [1:0]  CSR_CALLSIGN = 2'd1;

   typedef struct packed {
      logic [55:0] me;
      logic [1:0]  kind;
   } frame_type;

   function automatic logic [5:0] char_code(input logic [7:0] c);
      logic [5:0] code;
      code = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) code = c[5:0];
      else if (c == 8'h20) code = 6'd32;
      else if (c >= 8'h30 && c <= 8'h39) code = c[5:0];
      return code;
   endfunction

   // transition latitudes in units of 1e-8 degree
   function automatic logic [33:0] nl_limit(input logic [5:0] idx);
      logic [33:0] t;
      case (idx)
         6'd0:  t = 34'd1047047130;
         6'd1:  t = 34'd1482817437;
         6'd2:  t = 34'd1818626357;
         6'd3:  t = 34'd2102939493;
         6'd4:  t = 34'd2354504487;
         6'd5:  t = 34'd2582924707;
         6'd6:  t = 34'd2793898710;
         6'd7:  t = 34'd2991135686;
         6'd8:  t = 34'd3177209708;
         6'd9:  t = 34'd3353993436;
         6'd10: t = 34'd3522899598;
         6'd11: t = 34'd3685025108;
         6'd12: t = 34'd3841241892;
         6'd13: t = 34'd3992256684;
         6'd14: t = 34'd4138651832;
         6'd15: t = 34'd4280914012;
         6'd16: t = 34'd4419454951;
         6'd17: t = 34'd4554626723;
         6'd18: t = 34'd4686733252;
         6'd19: t = 34'd4816039128;
         6'd20: t = 34'd4942776439;
         6'd21: t = 34'd5067150166;
         6'd22: t = 34'd5189342469;
         6'd23: t = 34'd5309516153;
         6'd24: t = 34'd5427817472;
         6'd25: t = 34'd5544378444;
         6'd26: t = 34'd5659318756;
         6'd27: t = 34'd5772747354;
         6'd28: t = 34'd5884763776;
         6'd29: t = 34'd5995459277;
         6'd30: t = 34'd6104917774;
         6'd31: t = 34'd6213216659;
         6'd32: t = 34'd6320427479;
         6'd33: t = 34'd6426616523;
         6'd34: t = 34'd6531845310;
         6'd35: t = 34'd6636171008;
         6'd36: t = 34'd6739646774;
         6'd37: t = 34'd6842322022;
         6'd38: t = 34'd6944242631;
         6'd39: t = 34'd7045451075;
         6'd40: t = 34'd7145986473;
         6'd41: t = 34'd7245884545;
         6'd42: t = 34'd7345177442;
         6'd43: t = 34'd7443893416;
         6'd44: t = 34'd7542056257;
         6'd45: t = 34'd7639684391;
         6'd46: t = 34'd7736789461;
         6'd47: t = 34'd7833374083;
         6'd48: t = 34'd7929428225;
         6'd49: t = 34'd8024923213;
         6'd50: t = 34'd8119801349;
         6'd51: t = 34'd8213956981;
         6'd52: t = 34'd8307199445;
         6'd53: t = 34'd8399173563;
         6'd54: t = 34'd8489166191;
         6'd55: t = 34'd8575541621;
         6'd56: t = 34'd8653536998;
         6'd57: t = 34'd8700000000;
         default: t = 34'd0;
      endcase
      return t;
   endfunction

endpackage

// ===== sv/adsb_front.sv =====
// ----------------------------------------------------------------------------
// adsb_front
// accepts ticks, picks the message kind and builds the 56-bit ME field
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_latitude,
   input  logic signed [31:0]      req_longitude,
   input  logic signed [16:0]      req_altitude,
   input  logic [63:0]             callsign,
   output logic                    q_push,
   output adsb_pkg::frame_type     q_push_data,
   input  logic                    q_full
);
   import adsb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PROD = 5'b00010,
      ST_SRCH = 5'b00100,
      ST_CPR  = 5'b01000,
      ST_PUSH = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [1:0]         kind_ff, kind_in;
   logic [31:0]        lat_ff, lat_in;
   logic [31:0]        lon_ff, lon_in;
   logic signed [16:0] alt_ff, alt_in;
   logic [31:0]        abs_ff, abs_in;
   logic [56:0]        prod_ff, prod_in;
   logic [5:0]         lo_ff, lo_in;
   logic [5:0]         hi_ff, hi_in;
   logic [31:0]        plat_ff, plat_in;
   logic [31:0]        plon_ff, plon_in;
   logic [10:0]        n_ff, n_in;

   logic               accept;
   logic [6:0]         mid_sum;
   logic [5:0]         mid;
   logic [56:0]        thr;
   logic               f;
   logic [5:0]         nl;
   logic [5:0]         nlc;
   logic [5:0]         zlat;
   logic signed [16:0] alt_cl;
   logic [15:0]        alt_ofs;
   logic [32:0]        alt_prod;
   logic [31:0]        lat_sum;
   logic [31:0]        lon_sum;
   logic [11:0]        altf;
   logic [55:0]        me_id;
   logic [55:0]        me_pos;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign f       = (kind_ff == KIND_ODD);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[6:1];
   assign thr     = {2'b00, nl_limit(mid), 21'd0};

   assign nl   = 6'(NL_MAX - {1'b0, lo_ff});
   assign nlc  = (nl > (6'(f) + 6'd1)) ? (nl - 6'(f)) : 6'd1;
   assign zlat = ZONES_LAT - 6'(f);

   always_comb begin
      alt_cl = alt_ff;
      if (alt_ff < ALT_MIN) alt_cl = ALT_MIN;
      else if (alt_ff > ALT_MAX) alt_cl = ALT_MAX;
   end
   assign alt_ofs  = 16'($unsigned(alt_cl) + ALT_OFFSET);
   assign alt_prod = 33'(alt_ofs) * 33'(RECIP_25);

   assign lat_sum = plat_ff + CPR_HALF;
   assign lon_sum = plon_ff + CPR_HALF;
   assign altf    = {n_ff[10:4], 1'b1, n_ff[3:0]};
   assign me_pos  = {TC_AIRPOS, 3'b000, altf, 1'b0, f, lat_sum[31:15], lon_sum[31:15]};

   always_comb begin
      me_id = {TC_IDENT, CAT_IDENT, 48'd0};
      for (int i = 0; i < 8; i++) begin
         me_id[47 - 6 * i -: 6] = char_code(callsign[63 - 8 * i -: 8]);
      end
   end

   assign q_push_data.me   = (kind_ff == KIND_ID) ? me_id : me_pos;
   assign q_push_data.kind = kind_ff;
   assign q_push           = (state_ff == ST_PUSH) && !q_full;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      alt_in   = alt_ff;
      abs_in   = abs_ff;
      prod_in  = prod_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      plat_in  = plat_ff;
      plon_in  = plon_ff;
      n_in     = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lat_in   = req_latitude;
               lon_in   = req_longitude;
               alt_in   = req_altitude;
               abs_in   = req_latitude[31] ? (~req_latitude + 32'd1) : req_latitude;
               if (cnt_ff == 3'd0) kind_in = KIND_ID;
               else if (cnt_ff[0]) kind_in = KIND_ODD;
               else kind_in = KIND_EVEN;
               cnt_in   = (cnt_ff >= CNT_LAST) ? 3'd0 : cnt_ff + 3'd1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            prod_in  = 57'(abs_ff) * 57'(NL_SCALE);
            lo_in    = 6'd0;
            hi_in    = NL_COUNT;
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            if (lo_ff == hi_ff) begin
               state_in = ST_CPR;
            end else if (prod_ff > thr) begin
               lo_in = mid + 6'd1;
            end else begin
               hi_in = mid;
            end
         end
         ST_CPR: begin
            plat_in  = 32'(lat_ff * 32'(zlat));
            plon_in  = 32'(lon_ff * 32'(nlc));
            n_in     = alt_prod[31:21];
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!q_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      lat_ff  <= lat_in;
      lon_ff  <= lon_in;
      alt_ff  <= alt_in;
      abs_ff  <= abs_in;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      plat_ff <= plat_in;
      plon_ff <= plon_in;
      n_ff    <= n_in;
   end

   `ASSERT_PROP(a_srch_bounds, clock, reset, (state_ff == ST_SRCH) |-> (lo_ff <= hi_ff && hi_ff <= NL_COUNT), "zone search range broken")
   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CNT_LAST, "message counter out of range")

endmodule

// ===== sv/adsb_queue.sv =====
// ----------------------------------------------------------------------------
// adsb_queue
// small fifo of encoded messages between front and serializer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  adsb_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output adsb_pkg::frame_type pop_data,
   output logic                valid
);
   import adsb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   frame_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_FULL);
   assign valid    = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      if (pop) rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && !valid, "pop from empty queue")

endmodule

// ===== sv/adsb_back.sv =====
// ----------------------------------------------------------------------------
// adsb_back
// serializes one queued message into the fourteen frame bytes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [23:0]         icao_address,
   input  logic                q_valid,
   input  adsb_pkg::frame_type q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_byte,
   output logic [1:0]          rsp_message_kind
);
   import adsb_pkg::*;

   frame_type  frame_ff, frame_in;
   logic       loaded_ff, loaded_in;
   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] kind_ff, kind_in;

   logic       out_free;
   logic       at_last;
   logic [7:0] sel_byte;

   assign out_free = !valid_ff || !rsp_stall;
   assign at_last  = (idx_ff == LAST_BYTE);
   assign q_pop    = q_valid && (!loaded_ff || (out_free && at_last));

   always_comb begin
      case (idx_ff)
         4'd0:    sel_byte = FRAME_HEAD;
         4'd1:    sel_byte = icao_address[23:16];
         4'd2:    sel_byte = icao_address[15:8];
         4'd3:    sel_byte = icao_address[7:0];
         4'd4:    sel_byte = frame_ff.me[55:48];
         4'd5:    sel_byte = frame_ff.me[47:40];
         4'd6:    sel_byte = frame_ff.me[39:32];
         4'd7:    sel_byte = frame_ff.me[31:24];
         4'd8:    sel_byte = frame_ff.me[23:16];
         4'd9:    sel_byte = frame_ff.me[15:8];
         4'd10:   sel_byte = frame_ff.me[7:0];
         default: sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      frame_in  = frame_ff;
      loaded_in = loaded_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      kind_in   = kind_ff;
      if (out_free) begin
         valid_in = loaded_ff;
         if (loaded_ff) begin
            byte_in = sel_byte;
            last_in = at_last;
            kind_in = frame_ff.kind;
            idx_in  = at_last ? 4'd0 : idx_ff + 4'd1;
            if (at_last) loaded_in = 1'b0;
         end
      end
      if (q_pop) begin
         frame_in  = q_data;
         loaded_in = 1'b1;
         idx_in    = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         idx_ff    <= 4'd0;
         valid_ff  <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      kind_ff  <= kind_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_byte   = byte_ff;
   assign rsp_last_byte    = last_ff;
   assign rsp_message_kind = kind_ff;

   `ASSERT_PROP(a_idx_range, clock, reset, loaded_ff |-> (idx_ff <= LAST_BYTE), "byte index past frame end")

endmodule

// ===== sv/adsb_extended_squitter_encoder.sv =====
// ----------------------------------------------------------------------------
// adsb_extended_squitter_encoder: DF 17 frame encoder, one frame per tick
// a tick passes front, queue and serializer; one byte a cycle while rsp_stall is low
// the front takes the next tick once the last is queued; the serializer sets the rate
// front steps idle, product, search, cpr, push (zone search runs 5 or 6 halving steps)
// reset: counter, queue, req_stall, rsp_valid and both config registers cleared to zero
// ----------------------------------------------------------------------------
module adsb_extended_squitter_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_latitude,
   input  logic signed [31:0] req_longitude,
   input  logic signed [16:0] req_altitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte,
   output logic [1:0]         rsp_message_kind,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import adsb_pkg::*;

   logic [23:0] icao_ff, icao_in;
   logic [63:0] callsign_ff, callsign_in;
   logic        csr_write;

   logic        q_push;
   frame_type   q_push_data;
   logic        q_full;
   logic        q_pop;
   frame_type   q_pop_data;
   logic        q_valid;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      icao_in     = icao_ff;
      callsign_in = callsign_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ICAO:     icao_in     = csr_wdata[23:0];
            CSR_CALLSIGN: callsign_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icao_ff     <= 24'd0;
         callsign_ff <= 64'd0;
      end else begin
         icao_ff     <= icao_in;
         callsign_ff <= callsign_in;
      end
   end

   adsb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_latitude  (req_latitude),
      .req_longitude (req_longitude),
      .req_altitude  (req_altitude),
      .callsign      (callsign_ff),
      .q_push        (q_push),
      .q_push_data   (q_push_data),
      .q_full        (q_full)
   );

   adsb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .valid     (q_valid)
   );

   adsb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .icao_address     (icao_ff),
      .q_valid          (q_valid),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_message_kind (rsp_message_kind)
   );

endmodule

// ===== bench/tb_adsb_extended_squitter_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsb_extended_squitter_encoder
// sends transmit ticks into the encoder and checks every frame byte against a
// local model of the message rotation, callsign coding, altitude code and cpr
// position fields, with random gaps on both sides and several address and
// callsign settings
// ----------------------------------------------------------------------------
module tb_adsb_extended_squitter_encoder;
   import adsb_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int RANDOM_PHASES   = 5;
   localparam int TICKS_PER_PHASE = 70;

   typedef struct {
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      logic signed [16:0] alt;
   } tick_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic [1:0] kind;
   } frame_byte_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_latitude  = '0;
   logic signed [31:0] req_longitude = '0;
   logic signed [16:0] req_altitude  = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last_byte;
   logic [1:0]         rsp_message_kind;
   logic               csr_valid     = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index     = '0;
   logic [63:0]        csr_wdata     = '0;

   // transition latitudes in units of 1e-8 degree
   logic [33:0] zone_edge [0:57] = '{
      34'd1047047130, 34'd1482817437, 34'd1818626357, 34'd2102939493, 34'd2354504487,
      34'd2582924707, 34'd2793898710, 34'd2991135686, 34'd3177209708, 34'd3353993436,
      34'd3522899598, 34'd3685025108, 34'd3841241892, 34'd3992256684, 34'd4138651832,
      34'd4280914012, 34'd4419454951, 34'd4554626723, 34'd4686733252, 34'd4816039128,
      34'd4942776439, 34'd5067150166, 34'd5189342469, 34'd5309516153, 34'd5427817472,
      34'd5544378444, 34'd5659318756, 34'd5772747354, 34'd5884763776, 34'd5995459277,
      34'd6104917774, 34'd6213216659, 34'd6320427479, 34'd6426616523, 34'd6531845310,
      34'd6636171008, 34'd6739646774, 34'd6842322022, 34'd6944242631, 34'd7045451075,
      34'd7145986473, 34'd7245884545, 34'd7345177442, 34'd7443893416, 34'd7542056257,
      34'd7639684391, 34'd7736789461, 34'd7833374083, 34'd7929428225, 34'd8024923213,
      34'd8119801349, 34'd8213956981, 34'd8307199445, 34'd8399173563, 34'd8489166191,
      34'd8575541621, 34'd8653536998, 34'd8700000000
   };

   string       call_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ 0123456789";

   tick_type       pending_ticks [$];
   frame_byte_type frame_bytes_due [$];
   tick_type       tick_on_bus;
   frame_byte_type due;

   logic [2:0]  msg_count     = 3'd0;
   logic [23:0] icao_reg      = '0;
   logic [63:0] callsign_reg  = '0;

   int          tx_gap        = 0;
   int          rx_stall_left = 0;
   int          idle_odds     = 4;
   bit          calm          = 1'b0;
   int          cycle_count   = 0;
   int          error_count   = 0;
   int          bytes_checked = 0;
   int          frames_id     = 0;
   int          frames_odd    = 0;
   int          frames_even   = 0;
   int          settings_seen = 0;

   adsb_extended_squitter_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_latitude     (req_latitude),
      .req_longitude    (req_longitude),
      .req_altitude     (req_altitude),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_message_kind (rsp_message_kind),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [5:0] six_bit_char(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return 6'(c - "A" + 8'd1);
      if (c == " ") return 6'd32;
      if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd48);
      return 6'd0;
   endfunction

   // largest latitude magnitude that still sits at or below transition i
   function automatic logic signed [31:0] zone_bound_lat(input int i);
      return 32'(({30'd0, zone_edge[i]} << 21) / 64'd17578125);
   endfunction

   function automatic logic [16:0] cpr_bin(input logic signed [31:0] angle, input int zones);
      logic signed [63:0] a64;
      logic signed [63:0] p;
      a64 = angle;
      p = a64 * zones + 64'sd16384;
      return p[31:15];
   endfunction

   function automatic logic [55:0] position_me(input tick_type t, input logic f);
      logic signed [63:0] s;
      logic [63:0]        mag;
      int                 zones;
      int                 lon_zones;
      int                 ff;
      int                 n;
      logic signed [17:0] a;
      logic [10:0]        code;
      s = t.lat;
      mag = (s < 0) ? -s : s;
      zones = 59;
      for (int i = 0; i < 58; i++)
         if ((mag * 64'd17578125) > ({30'd0, zone_edge[i]} << 21)) zones--;
      ff = f;
      lon_zones = (zones > ff + 1) ? zones - ff : 1;
      a = t.alt;
      if (a < -18'sd1000) a = -18'sd1000;
      if (a > 18'sd50175) a = 18'sd50175;
      n = (int'(a) + 1000) / 25;
      code = n[10:0];
      return {TC_AIRPOS, 3'b000, code[10:4], 1'b1, code[3:0], 1'b0, f,
              cpr_bin(t.lat, 60 - ff), cpr_bin(t.lon, lon_zones)};
   endfunction

   task automatic predict_frame(input tick_type t);
      logic [55:0] me;
      logic [1:0]  kind;
      logic [7:0]  fb [14];
      if (msg_count == 3'd0) begin
         kind = KIND_ID;
         frames_id++;
         me = {TC_IDENT, CAT_IDENT, 48'd0};
         for (int i = 0; i < 8; i++)
            me[47 - 6 * i -: 6] = six_bit_char(callsign_reg[63 - 8 * i -: 8]);
      end else if (msg_count[0]) begin
         kind = KIND_ODD;
         frames_odd++;
         me = position_me(t, 1'b1);
      end else begin
         kind = KIND_EVEN;
         frames_even++;
         me = position_me(t, 1'b0);
      end
      fb[0] = FRAME_HEAD;
      fb[1] = icao_reg[23:16];
      fb[2] = icao_reg[15:8];
      fb[3] = icao_reg[7:0];
      for (int k = 0; k < 7; k++) fb[4 + k] = me[55 - 8 * k -: 8];
      fb[11] = 8'd0;
      fb[12] = 8'd0;
      fb[13] = 8'd0;
      for (int k = 0; k < 14; k++)
         frame_bytes_due.push_back('{data: fb[k], last: (k == LAST_BYTE), kind: kind});
      msg_count = (msg_count >= CNT_LAST) ? 3'd0 : msg_count + 3'd1;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch at byte %0d: %s got %0h expected %0h",
               bytes_checked, field, got, want);
   endtask

   task automatic queue_tick(input logic signed [31:0] lat, lon, input logic signed [16:0] alt);
      pending_ticks.push_back('{lat: lat, lon: lon, alt: alt});
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ICAO) icao_reg = value[23:0];
      else if (idx == CSR_CALLSIGN) callsign_reg = value;
      settings_seen++;
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || frame_bytes_due.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_frame(tick_on_bus);
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               tick_on_bus = pending_ticks.pop_front();
               req_latitude <= tick_on_bus.lat;
               req_longitude <= tick_on_bus.lon;
               req_altitude <= tick_on_bus.alt;
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, idle_odds) == 0) tx_gap <= $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch("byte with nothing expected", rsp_frame_byte, 0);
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== due.data)
                  report_mismatch("frame_byte", rsp_frame_byte, due.data);
               if (rsp_last_byte !== due.last)
                  report_mismatch("last_byte", rsp_last_byte, due.last);
               if (rsp_message_kind !== due.kind)
                  report_mismatch("message_kind", rsp_message_kind, due.kind);
               bytes_checked++;
            end
         end
         if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, idle_odds * 4) == 0) begin
            rx_stall_left <= $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, frame_bytes_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [63:0]        word;
      logic signed [31:0] lat;
      logic signed [16:0] alt;
      int                 pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // address and callsign at their reset values
      queue_tick(0, 0, 0);
      queue_tick(32'sh12345678, 32'sh87654321, 5000);
      queue_tick(-32'sh12345678, 32'sh0F0F0F0F, 12000);
      wait_drained();

      write_register(CSR_ICAO, 64'hFFFFFF);
      write_register(CSR_CALLSIGN, "@AZ[ /09");
      queue_tick(32'sh40000000, 32'sh7FFFFFFF, 50175);
      queue_tick(32'shC0000000, 32'sh80000000, -1000);
      queue_tick(32'sh7FFFFFFF, 0, 17'h10000);
      queue_tick(32'sh80000000, 1, 17'h0FFFF);
      queue_tick(0, 0, 0);
      queue_tick(zone_bound_lat(57), -1, -1001);
      queue_tick(zone_bound_lat(57) + 1, 32'sh7FFFFFFF, 50176);
      queue_tick(-zone_bound_lat(0), 12345, -999);
      queue_tick(-zone_bound_lat(0) - 1, -12345, -976);
      queue_tick(1, -1, 24);
      queue_tick(-1, 1, 25);
      wait_drained();

      write_register(CSR_ICAO, 64'h0);
      write_register(CSR_CALLSIGN, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_tick(zone_bound_lat(56), 32'sh12345678, 30000);
      queue_tick(zone_bound_lat(56) + 1, 32'shEDCBA987, 30000);
      queue_tick(-zone_bound_lat(55), 32'sh80000000, 100);
      queue_tick(-zone_bound_lat(55) - 1, 32'sh7FFFFFFF, 100);
      queue_tick(zone_bound_lat(28), 32'sh40000000, 49999);
      queue_tick(zone_bound_lat(28) + 1, 32'shC0000000, 50150);
      queue_tick(32'sh3FFFFFFF, 32'sh40000000, -1000);
      queue_tick(32'sh00004000, 32'sh00004000, 0);
      queue_tick(-32'sh00004000, -32'sh00004000, 0);
      queue_tick(zone_bound_lat(0), 32'sh55555555, 1000);
      queue_tick(zone_bound_lat(0) + 1, 32'shAAAAAAAA, 1000);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_register(CSR_ICAO, {$urandom, $urandom});
         for (int i = 0; i < 8; i++)
            word[63 - 8 * i -: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                    : call_chars[$urandom_range(0, 36)];
         write_register(CSR_CALLSIGN, (ph == 0) ? 64'd0 : word);
         idle_odds = (ph % 2) ? 3 : 10;
         calm = (ph == RANDOM_PHASES - 1);
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
               lat = $urandom_range(0, 32'h80000000) - 32'sh40000000;
            end else if (pick < 17) begin
               lat = zone_bound_lat($urandom_range(0, 57)) + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1)) lat = -lat;
            end else if (pick < 19) begin
               lat = $urandom_range(0, 32'h1FFFF) - 32'sh10000;
            end else begin
               lat = $urandom;
            end
            pick = $urandom_range(0, 9);
            if (pick < 8) alt = 17'($urandom_range(0, 51175) - 1000);
            else if (pick == 8) alt = $urandom_range(0, 1) ? 17'(-1001 + $urandom_range(0, 1))
                                                           : 17'(50175 + $urandom_range(0, 1));
            else alt = 17'($urandom_range(0, 131071));
            queue_tick(lat, $urandom, alt);
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      $display("checked %0d bytes: %0d identification, %0d odd and %0d even position frames",
               bytes_checked, frames_id, frames_odd, frames_even);
      $display("register writes: %0d, mismatches: %0d", settings_seen, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
